[rtl/spie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spie_pkg;

    localparam int VALUE_W  = 64;
    localparam int BYTE_W   = 8;
    localparam int LOW_W    = 6;
    localparam int GROUP_W  = 7;
    localparam int MAG_W    = VALUE_W - 1;
    localparam int N_GROUPS = (MAG_W - LOW_W + GROUP_W - 1) / GROUP_W;
    localparam int REST_W   = N_GROUPS * GROUP_W;

    localparam logic [BYTE_W-1:0] SIGN_FLAG = 8'h40;
    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3F;
    localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] MORE_FLAG = 8'h80;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic [GROUP_W-1:0]        group_t;
    typedef logic [REST_W-1:0]         rest_t;
    typedef logic [N_GROUPS-1:0]       nz_t;

endpackage
`default_nettype wire

[rtl/spie_value_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface spie_value_if;
    logic                 valid;
    logic                 ready;
    spie_pkg::value_t     value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

[rtl/spie_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface spie_byte_if;
    logic                 valid;
    logic                 ready;
    spie_pkg::byte_t      out_byte;
    logic                 last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

[rtl/signed_packed_int_encoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | payload               | handshake
// value_ch  | in  | value (64, signed)    | valid / ready
// byte_ch   | out | out_byte (8), last    | valid / ready
//
// a value is accepted, then sent one byte per cycle while the output register is not stalled:
// 1 to 10 bytes per value, set by the 7-bit group shift register feeding the output register.
// a new value is taken in the cycle after its last byte enters the output register.
// a stalled output register holds the group shift register in place.
// reset clears the busy flag, the group flags and the output valid; no clearing pass.
module signed_packed_int_encoder_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    spie_value_if.sink    value_ch,
    spie_byte_if.source   byte_ch
);
    import spie_pkg::*;

    logic               busy_reg,  busy_next;
    logic [GROUP_W-1:0] cur_reg,   cur_next;
    rest_t              rest_reg,  rest_next;
    nz_t                nz_reg,    nz_next;
    logic               ov_reg,    ov_next;
    byte_t              ob_reg,    ob_next;
    logic               last_reg,  last_next;

    logic [MAG_W-1:0]   mag;
    rest_t              rest_load;
    nz_t                nz_load;
    logic               more;
    logic               step;
    logic               take;

    // magnitude: complement of a negative value, sign bit dropped
    assign mag = value_ch.value[VALUE_W-1] ? ~value_ch.value[MAG_W-1:0]
                                           : value_ch.value[MAG_W-1:0];
    assign rest_load = rest_t'(mag[MAG_W-1:LOW_W]);

    always_comb
    begin
        for (int k = 0; k < N_GROUPS; k++)
        begin
            nz_load[k] = |rest_load[k*GROUP_W +: GROUP_W];
        end
    end

    assign take = value_ch.valid && value_ch.ready;
    assign step = busy_reg && (!ov_reg || byte_ch.ready);
    assign more = |nz_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        rest_next = rest_reg;
        nz_next   = nz_reg;
        ov_next   = ov_reg;
        ob_next   = ob_reg;
        last_next = last_reg;
        if (ov_reg && byte_ch.ready)
        begin
            ov_next = 1'b0;
        end
        if (step)
        begin
            ov_next   = 1'b1;
            ob_next   = more ? ({1'b0, cur_reg} | MORE_FLAG) : {1'b0, cur_reg};
            last_next = !more;
            cur_next  = rest_reg[GROUP_W-1:0] & LOW7_MASK[GROUP_W-1:0];
            rest_next = rest_reg >> GROUP_W;
            nz_next   = nz_reg >> 1;
            busy_next = more;
        end
        if (take)
        begin
            busy_next = 1'b1;
            cur_next  = (value_ch.value[VALUE_W-1] ? SIGN_FLAG[GROUP_W-1:0]
                                                    : {GROUP_W{1'b0}})
                      | {1'b0, mag[LOW_W-1:0] & LOW6_MASK[LOW_W-1:0]};
            rest_next = rest_load;
            nz_next   = nz_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            nz_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            nz_reg   <= nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rest_reg <= rest_next;
        ob_reg   <= ob_next;
        last_reg <= last_next;
    end

    assign value_ch.ready   = !busy_reg;
    assign byte_ch.valid    = ov_reg;
    assign byte_ch.out_byte = ob_reg;
    assign byte_ch.last     = last_reg;

`ifndef SYNTHESIS
    // an accepted item always starts a byte sequence
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy_reg)
        else $error("accepted item did not start encoding");

    // continuation flag and last marker must agree
    a_more_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (ob_reg[BYTE_W-1] == !last_reg))
        else $error("continuation bit disagrees with last");

    // group flags are drained once an encoding finishes
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (nz_reg == '0))
        else $error("group flags left over while idle");

    // a stalled output byte holds its value
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !byte_ch.ready) |=> (ov_reg && $stable(ob_reg) && $stable(last_reg)))
        else $error("stalled output byte changed");
`endif

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import spie_pkg::*;

    class byte_scoreboard;
        byte_t exp_byte[$];
        logic  exp_last[$];
        int    fails = 0;

        // packed encoding of one value, low group first
        function void note_value(value_t v);
            logic [VALUE_W-1:0] mag;
            byte_t              cur;
            int                 n;
            mag = v;
            cur = '0;
            n = 0;
            if (v[VALUE_W-1])
            begin
                cur = SIGN_FLAG;
                mag = ~v;
            end
            cur = cur | (byte_t'(mag) & LOW6_MASK);
            mag = mag >> LOW_W;
            while (mag != 0 && n < N_GROUPS)
            begin
                exp_byte.push_back(cur | MORE_FLAG);
                exp_last.push_back(1'b0);
                n++;
                cur = byte_t'(mag) & LOW7_MASK;
                mag = mag >> GROUP_W;
            end
            exp_byte.push_back(cur);
            exp_last.push_back(1'b1);
        endfunction

        function void check_byte(byte_t b, logic l);
            byte_t eb;
            logic  el;
            if (exp_byte.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected item: out_byte=%h last=%b", b, l);
                return;
            end
            eb = exp_byte.pop_front();
            el = exp_last.pop_front();
            if (b !== eb || l !== el)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: out_byte exp %h got %h, last exp %b got %b",
                             eb, b, el, l);
            end
        endfunction

        function int pending();
            return exp_byte.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   src_burst;
    bit   sink_burst;

    spie_value_if v_if ();
    spie_byte_if  b_if ();

    byte_scoreboard sb;

    signed_packed_int_encoder_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (v_if),
        .byte_ch  (b_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        v_if.valid = 1'b0;
        v_if.value = '0;
        b_if.ready = 1'b0;
        src_burst = 1'b0;
        sink_burst = 1'b0;
        sb = new;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (v_if.valid && v_if.ready)
                sb.note_value(v_if.value);
            if (b_if.valid && b_if.ready)
                sb.check_byte(b_if.out_byte, b_if.last);
        end
    end

    // receiver: random stalls, with stretches of none
    initial
    begin
        int gap;
        int cnt;
        cnt = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (cnt % 40 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            cnt++;
            gap = sink_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                b_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            b_if.ready <= 1'b1;
            @(posedge clk);
            while (!b_if.valid) @(posedge clk);
        end
    end

    task automatic send_value(input value_t v);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            v_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        v_if.valid <= 1'b1;
        v_if.value <= v;
        @(posedge clk);
        while (!v_if.ready) @(posedge clk);
    endtask

    // random value with a random encoded length of 1 to 10 bytes
    function automatic value_t rand_value();
        logic [VALUE_W-1:0] m;
        int                 nb;
        int                 w;
        m = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
            return value_t'(m);
        nb = $urandom_range(1, N_GROUPS + 1);
        w = LOW_W + GROUP_W * (nb - 1);
        if (w > MAG_W)
            w = MAG_W;
        m = m & ((64'h1 << w) - 64'h1);
        if ($urandom_range(0, 1))
            m[w-1] = 1'b1;
        if ($urandom_range(0, 1))
            m = ~m;
        return value_t'(m);
    endfunction

    initial
    begin
        value_t directed[$];
        directed = '{
            64'sd0, -64'sd1, 64'sd1, -64'sd2, 64'sd63, 64'sd64, -64'sd64, -64'sd65,
            64'sd8191, 64'sd8192, -64'sd8193, 64'sd32767, -64'sd32768,
            64'sd2147483647, -64'sd2147483648,
            64'sh3FFF_FFFF_FFFF_FFFF, 64'sh4000_0000_0000_0000,
            64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
            64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA
        };
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        foreach (directed[i])
            send_value(directed[i]);
        for (int i = 0; i < 450; i++)
        begin
            if (i % 50 == 0)
                src_burst = ($urandom_range(0, 3) == 0);
            if (i == 200)
            begin
                // hold off until the output side has drained
                v_if.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            send_value(rand_value());
        end
        v_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/spie_pkg.sv
rtl/spie_value_if.sv
rtl/spie_byte_if.sv
rtl/signed_packed_int_encoder_unit.sv
bench/testbench.sv
